[rtl/disc_coverage_count_update_macros.svh]
// Assertion macros used by the disc coverage count RTL.
`ifndef DISC_COVERAGE_COUNT_UPDATE_MACROS_SVH
`define DISC_COVERAGE_COUNT_UPDATE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DCCU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DCCU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/dccu_pkg.sv]
// Types, codes and defaults for the disc coverage count block.
`timescale 1ns / 1ps

package dccu_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int MAX_RADIUS_DEF = 7;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic       CMD_STAMP = 1'b0;
  localparam logic       CMD_READ  = 1'b1;
  localparam logic [1:0] DELTA_UP   = 2'b01;
  localparam logic [1:0] DELTA_DOWN = 2'b11;

  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS     = 2'd2;

  localparam logic [6:0] MAP_WIDTH_RST  = 7'd64;
  localparam logic [6:0] MAP_HEIGHT_RST = 7'd64;
  localparam logic [2:0] RADIUS_RST     = 3'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDWAIT,
    ST_STAMP,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Current disc offset from the walk sequencer (two's complement dj, dk).
  typedef struct packed {
    logic       active;
    logic       last;
    logic       hit;
    logic [4:0] dj;
    logic [4:0] dk;
  } offset_t;

endpackage

[rtl/dccu_if.sv]
// Stream interfaces for the command and result channels.
`timescale 1ns / 1ps

interface dccu_in_if;
  logic              valid;
  logic              ready;
  logic              command;
  logic [5:0]        pos_x;
  logic [5:0]        pos_y;
  logic signed [1:0] delta;

  modport source (output valid, command, pos_x, pos_y, delta, input ready);
  modport sink   (input valid, command, pos_x, pos_y, delta, output ready);
endinterface

interface dccu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_value;
  logic [7:0]  cells_changed;

  modport source (output valid, cell_value, cells_changed, input ready);
  modport sink   (input valid, cell_value, cells_changed, output ready);
endinterface

[rtl/disc_coverage_count_update.sv]
// Top level of the disc coverage count grid with stamp and read commands.
// Usage:
//   Commands arrive on in_i (valid/ready). A read returns one cell's count in
//   cell_value; a stamp adds +1 or -1 to every cell of the disc around
//   (pos_x,pos_y) and returns how many counts moved in cells_changed.
//   Each command yields one result on out_o (valid/ready).
//   Registers map_width, map_height and radius sit on the APB port at 0x0,
//   0x4 and 0x8; write them only while the block is idle.
// Sequence:
//   A read passes through the read-wait and done states into the output
//   register. A stamp walks the (2*r+1)^2 square, r the clamped radius,
//   with the offset sequencer stepping one cell per cycle with one count
//   memory read and one write per cycle, then drains. A stamp with a
//   meaningless delta goes straight to done. One command is in work at a time.
// Reset and stalls:
//   After reset a clearing pass zeroes the count memory, one entry a cycle,
//   all MAX_WIDTH*MAX_HEIGHT entries; no command is taken then.
//   A result waits in the output register while the receiver stalls; the next
//   command is still taken, and its result waits until the register frees.
`timescale 1ns / 1ps

`include "disc_coverage_count_update_macros.svh"

module disc_coverage_count_update #(
  parameter int MAX_WIDTH  = dccu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dccu_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = dccu_pkg::MAX_RADIUS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dccu_in_if.sink     in_i,
  dccu_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  dccu_pkg::state_e state_q, state_d;

  logic [6:0]  map_width_q, map_height_q;
  logic [2:0]  radius_q;
  logic [AW-1:0] clr_cnt_q;
  logic        clr_last;

  logic [5:0]  x_q, y_q;
  logic        up_q;
  logic        rd_grid_q;
  logic [15:0] res_value_q;
  logic [7:0]  chg_q;

  logic        pend_q;
  logic [AW-1:0] pend_addr_q;

  logic        out_valid_q;
  logic [15:0] out_value_q;
  logic [7:0]  out_chg_q;

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0] mem_wdata;

  logic [6:0]  w_eff, h_eff;
  logic [3:0]  r_eff;
  logic        acc, delta_ok, rd_grid;
  logic [AW-1:0] rd_addr, cell_addr;
  logic [7:0]  cx, cy;
  logic        cell_ok;
  logic [15:0] new_val;
  logic        cell_moved;

  logic        seq_start, load_out;
  dccu_pkg::offset_t off;

  dccu_disc_walk u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (seq_start),
    .radius_i (r_eff),
    .off_o    (off)
  );

  // Clamp the grid and radius to what the storage holds
  always_comb begin
    w_eff = (32'(map_width_q) > MAX_WIDTH) ? 7'(MAX_WIDTH) : map_width_q;
    h_eff = (32'(map_height_q) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : map_height_q;
    r_eff = (32'(radius_q) > MAX_RADIUS) ? 4'(MAX_RADIUS) : {1'b0, radius_q};
  end

  assign acc      = in_i.valid && in_i.ready;
  assign delta_ok = (in_i.delta == dccu_pkg::DELTA_UP) || (in_i.delta == dccu_pkg::DELTA_DOWN);
  assign rd_grid  = ({1'b0, in_i.pos_x} < w_eff) && ({1'b0, in_i.pos_y} < h_eff);
  assign rd_addr  = AW'(32'(in_i.pos_y) * MAX_WIDTH + 32'(in_i.pos_x));

  // Cell under the current offset
  always_comb begin
    cx        = 8'(8'({2'b00, x_q}) + {{3{off.dj[4]}}, off.dj});
    cy        = 8'(8'({2'b00, y_q}) + {{3{off.dk[4]}}, off.dk});
    cell_ok   = off.active && off.hit && !cx[7] && !cy[7]
                && (cx[6:0] < w_eff) && (cy[6:0] < h_eff);
    cell_addr = AW'(32'(cy[6:0]) * MAX_WIDTH + 32'(cx[6:0]));
  end

  // Saturating update of the count read in the previous cycle
  always_comb begin
    new_val = rdata_q;
    if (up_q) begin
      if (rdata_q != dccu_pkg::COUNT_MAX) new_val = 16'(rdata_q + 16'd1);
    end else begin
      if (rdata_q != 16'd0) new_val = 16'(rdata_q - 16'd1);
    end
    cell_moved = (new_val != rdata_q);
  end

  assign clr_last = (clr_cnt_q == AW'(DEPTH - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dccu_pkg::ST_CLEAR: begin
        if (clr_last) state_d = dccu_pkg::ST_IDLE;
      end
      dccu_pkg::ST_IDLE: begin
        if (acc) begin
          if (in_i.command == dccu_pkg::CMD_READ) state_d = dccu_pkg::ST_RDWAIT;
          else if (delta_ok) state_d = dccu_pkg::ST_STAMP;
          else state_d = dccu_pkg::ST_DONE;
        end
      end
      dccu_pkg::ST_RDWAIT: state_d = dccu_pkg::ST_DONE;
      dccu_pkg::ST_STAMP: begin
        if (off.last) state_d = dccu_pkg::ST_DRAIN;
      end
      dccu_pkg::ST_DRAIN: state_d = dccu_pkg::ST_DONE;
      dccu_pkg::ST_DONE: begin
        if (load_out) state_d = dccu_pkg::ST_IDLE;
      end
      default: state_d = dccu_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_i.ready = 1'b0;
    seq_start  = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = cell_addr;
    load_out   = 1'b0;
    case (state_q)
      dccu_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (acc) begin
          if (in_i.command == dccu_pkg::CMD_READ) begin
            mem_re    = rd_grid;
            mem_raddr = rd_addr;
          end else begin
            seq_start = delta_ok;
          end
        end
      end
      dccu_pkg::ST_STAMP: mem_re = cell_ok;
      dccu_pkg::ST_DONE:  load_out = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  always_comb begin
    if (state_q == dccu_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = 16'd0;
    end else begin
      mem_we    = pend_q;
      mem_waddr = pend_addr_q;
      mem_wdata = new_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dccu_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == dccu_pkg::ST_CLEAR) clr_cnt_q <= AW'(clr_cnt_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      chg_q       <= '0;
      res_value_q <= '0;
    end else begin
      pend_q <= (state_q == dccu_pkg::ST_STAMP) && cell_ok;
      if (acc) begin
        chg_q       <= '0;
        res_value_q <= '0;
      end else begin
        if (pend_q && cell_moved && chg_q != 8'hFF) chg_q <= 8'(chg_q + 8'd1);
        if (state_q == dccu_pkg::ST_RDWAIT) res_value_q <= rd_grid_q ? rdata_q : 16'd0;
      end
    end
  end

  // Command payload, held for the length of the item
  always_ff @(posedge clk_i) begin
    pend_addr_q <= cell_addr;
    if (acc) begin
      x_q       <= in_i.pos_x;
      y_q       <= in_i.pos_y;
      up_q      <= (in_i.delta == dccu_pkg::DELTA_UP);
      rd_grid_q <= rd_grid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_value_q <= res_value_q;
      out_chg_q   <= chg_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.cell_value    = out_value_q;
  assign out_o.cells_changed = out_chg_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= dccu_pkg::MAP_WIDTH_RST;
      map_height_q <= dccu_pkg::MAP_HEIGHT_RST;
      radius_q     <= dccu_pkg::RADIUS_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        dccu_pkg::REG_MAP_WIDTH:  map_width_q  <= pwdata[6:0];
        dccu_pkg::REG_MAP_HEIGHT: map_height_q <= pwdata[6:0];
        dccu_pkg::REG_RADIUS:     radius_q     <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dccu_pkg::REG_MAP_WIDTH:  prdata = 32'(map_width_q);
      dccu_pkg::REG_MAP_HEIGHT: prdata = 32'(map_height_q);
      dccu_pkg::REG_RADIUS:     prdata = 32'(radius_q);
      default:                  prdata = 32'd0;
    endcase
  end

  assign pready = 1'b1;

  `DCCU_ASSERT_IMP(a_write_follows_read, clk_i, rst_ni, (mem_we && state_q != dccu_pkg::ST_CLEAR), pend_q)
  `DCCU_ASSERT_IMP(a_no_rmw_hazard, clk_i, rst_ni, (pend_q && mem_re), (pend_addr_q != mem_raddr))
  `DCCU_ASSERT_IMP(a_walk_in_stamp, clk_i, rst_ni, off.active, (state_q == dccu_pkg::ST_STAMP))
  `DCCU_ASSERT_NXT(a_done_holds, clk_i, rst_ni, (state_q == dccu_pkg::ST_DONE && !load_out), ($stable(chg_q) && state_q == dccu_pkg::ST_DONE))

endmodule

[rtl/dccu_disc_walk.sv]
// Offset sequencer: steps (dj,dk) over the square and tests each against the disc.
`timescale 1ns / 1ps

module dccu_disc_walk (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [3:0]       radius_i,
  output dccu_pkg::offset_t off_o
);

  logic       active_q, active_d;
  logic [4:0] j_q, j_d;
  logic [4:0] k_q, k_d;
  logic [3:0] r_q, r_d;

  logic [4:0] r_pos, r_neg;
  logic [3:0] abs_j, abs_k;
  logic [7:0] sq_j, sq_k, sq_r;
  logic [8:0] dist_sq;
  logic       k_end, last;

  assign r_pos = {1'b0, r_q};
  assign r_neg = 5'(~r_pos + 5'd1);

  // Squared distance compare, one offset per cycle
  always_comb begin
    abs_j   = j_q[4] ? 4'(~j_q + 5'd1) : j_q[3:0];
    abs_k   = k_q[4] ? 4'(~k_q + 5'd1) : k_q[3:0];
    sq_j    = 8'(abs_j) * 8'(abs_j);
    sq_k    = 8'(abs_k) * 8'(abs_k);
    sq_r    = 8'(r_q) * 8'(r_q);
    dist_sq = 9'(sq_j) + 9'(sq_k);
    k_end   = (k_q == r_pos);
    last    = k_end && (j_q == r_pos);
  end

  always_comb begin
    active_d = active_q;
    j_d      = j_q;
    k_d      = k_q;
    r_d      = r_q;
    if (start_i) begin
      active_d = 1'b1;
      r_d      = radius_i;
      j_d      = 5'(~{1'b0, radius_i} + 5'd1);
      k_d      = 5'(~{1'b0, radius_i} + 5'd1);
    end else if (active_q) begin
      if (last) begin
        active_d = 1'b0;
      end else if (k_end) begin
        k_d = r_neg;
        j_d = 5'(j_q + 5'd1);
      end else begin
        k_d = 5'(k_q + 5'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      j_q      <= '0;
      k_q      <= '0;
      r_q      <= '0;
    end else begin
      active_q <= active_d;
      j_q      <= j_d;
      k_q      <= k_d;
      r_q      <= r_d;
    end
  end

  assign off_o.active = active_q;
  assign off_o.last   = active_q && last;
  assign off_o.hit    = (dist_sq <= 9'(sq_r));
  assign off_o.dj     = j_q;
  assign off_o.dk     = k_q;

endmodule
